[src/ntcl_pkg.sv]
package ntcl_pkg;

    // Default group size and curve length.
    localparam int AVG_SAMPLES_DEF   = 8;
    localparam int TABLE_ENTRIES_DEF = 101;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 7;
    localparam int LIGHT_W  = 7;
    localparam int STATUS_W = 2;

    // Limit register reset values.
    localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST  = 12'd267;
    localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST = 12'd3157;

    // Light scaling: (FULL_SCALE - average) * PERCENT / FULL_SCALE.
    localparam logic [SAMPLE_W:0] FULL_SCALE = 13'd4096;
    localparam logic [6:0]        PERCENT    = 7'd100;

    // Depth of the queue between accumulator and conditioner.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_LOW_LIMIT  = 1'b0;
    localparam logic CFG_HIGH_LIMIT = 1'b1;

    // Range status codes.
    localparam logic [STATUS_W-1:0] STATUS_IN_TABLE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BELOW    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE    = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
    } t_limits;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_WALK,
        ST_EMIT
    } t_back_state;

    // Descending thermistor curve; entries past the stored ones read as zero.
    function automatic logic [SAMPLE_W-1:0] curve_value(input logic [7:0] idx);
        logic [SAMPLE_W-1:0] v;
        case (idx)
            8'd0: v = 12'd3041;   8'd1: v = 12'd3005;   8'd2: v = 12'd2968;
            8'd3: v = 12'd2930;   8'd4: v = 12'd2892;   8'd5: v = 12'd2854;
            8'd6: v = 12'd2815;   8'd7: v = 12'd2776;   8'd8: v = 12'd2737;
            8'd9: v = 12'd2697;   8'd10: v = 12'd2657;  8'd11: v = 12'd2616;
            8'd12: v = 12'd2576;  8'd13: v = 12'd2535;  8'd14: v = 12'd2495;
            8'd15: v = 12'd2454;  8'd16: v = 12'd2413;  8'd17: v = 12'd2372;
            8'd18: v = 12'd2331;  8'd19: v = 12'd2290;  8'd20: v = 12'd2249;
            8'd21: v = 12'd2209;  8'd22: v = 12'd2168;  8'd23: v = 12'd2128;
            8'd24: v = 12'd2088;  8'd25: v = 12'd2048;  8'd26: v = 12'd2008;
            8'd27: v = 12'd1969;  8'd28: v = 12'd1930;  8'd29: v = 12'd1891;
            8'd30: v = 12'd1853;  8'd31: v = 12'd1815;  8'd32: v = 12'd1778;
            8'd33: v = 12'd1741;  8'd34: v = 12'd1704;  8'd35: v = 12'd1668;
            8'd36: v = 12'd1632;  8'd37: v = 12'd1597;  8'd38: v = 12'd1562;
            8'd39: v = 12'd1528;  8'd40: v = 12'd1495;  8'd41: v = 12'd1461;
            8'd42: v = 12'd1429;  8'd43: v = 12'd1397;  8'd44: v = 12'd1365;
            8'd45: v = 12'd1334;  8'd46: v = 12'd1304;  8'd47: v = 12'd1274;
            8'd48: v = 12'd1245;  8'd49: v = 12'd1216;  8'd50: v = 12'd1188;
            8'd51: v = 12'd1160;  8'd52: v = 12'd1133;  8'd53: v = 12'd1107;
            8'd54: v = 12'd1081;  8'd55: v = 12'd1056;  8'd56: v = 12'd1031;
            8'd57: v = 12'd1006;  8'd58: v = 12'd983;   8'd59: v = 12'd959;
            8'd60: v = 12'd937;   8'd61: v = 12'd915;   8'd62: v = 12'd893;
            8'd63: v = 12'd872;   8'd64: v = 12'd851;   8'd65: v = 12'd831;
            8'd66: v = 12'd811;   8'd67: v = 12'd792;   8'd68: v = 12'd773;
            8'd69: v = 12'd755;   8'd70: v = 12'd737;   8'd71: v = 12'd719;
            8'd72: v = 12'd702;   8'd73: v = 12'd685;   8'd74: v = 12'd669;
            8'd75: v = 12'd653;   8'd76: v = 12'd638;   8'd77: v = 12'd623;
            8'd78: v = 12'd608;   8'd79: v = 12'd594;   8'd80: v = 12'd580;
            8'd81: v = 12'd566;   8'd82: v = 12'd553;   8'd83: v = 12'd540;
            8'd84: v = 12'd528;   8'd85: v = 12'd515;   8'd86: v = 12'd503;
            8'd87: v = 12'd492;   8'd88: v = 12'd480;   8'd89: v = 12'd469;
            8'd90: v = 12'd458;   8'd91: v = 12'd448;   8'd92: v = 12'd438;
            8'd93: v = 12'd428;   8'd94: v = 12'd418;   8'd95: v = 12'd409;
            8'd96: v = 12'd399;   8'd97: v = 12'd390;   8'd98: v = 12'd381;
            8'd99: v = 12'd373;   8'd100: v = 12'd365;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/ntcl_front.sv]
module ntcl_front #(
    parameter int AVG_SAMPLES = ntcl_pkg::AVG_SAMPLES_DEF,
    parameter int SUM_W       = ntcl_pkg::SAMPLE_W + $clog2(AVG_SAMPLES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ntcl_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [SUM_W-1:0]              o_push_sum
);

    localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic             last;
    logic             accept;

    // The last word of a group needs room in the queue; the others never wait.
    assign last       = (r_count == LAST_CNT);
    assign o_ready    = !(last && i_full);
    assign accept     = i_valid && o_ready;
    assign o_push_sum = r_sum + SUM_W'(i_sample);
    assign o_push     = accept && last;

    // Running sum and word count of the current group.
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (accept) begin
            if (last) begin
                n_sum   = '0;
                n_count = '0;
            end else begin
                n_sum   = o_push_sum;
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule

[src/ntcl_queue.sv]
module ntcl_queue #(
    parameter int WIDTH = ntcl_pkg::SAMPLE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(ntcl_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ntcl_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ntcl_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ntcl_pkg::QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] r_mem [ntcl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/ntcl_back.sv]
module ntcl_back #(
    parameter int AVG_SAMPLES   = ntcl_pkg::AVG_SAMPLES_DEF,
    parameter int TABLE_ENTRIES = ntcl_pkg::TABLE_ENTRIES_DEF,
    parameter int SUM_W         = ntcl_pkg::SAMPLE_W + $clog2(AVG_SAMPLES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ntcl_pkg::t_limits             i_limits,
    input  logic                          i_q_valid,
    input  logic [SUM_W-1:0]              i_q_sum,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ntcl_pkg::SAMPLE_W-1:0] o_average,
    output logic [ntcl_pkg::TEMP_W-1:0]   o_temperature,
    output logic [ntcl_pkg::LIGHT_W-1:0]  o_light_percent,
    output logic [ntcl_pkg::STATUS_W-1:0] o_range_status
);

    localparam int SW     = ntcl_pkg::SAMPLE_W;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    // Reciprocal of the group size, exact for every sum below 2**SUM_W.
    localparam int REC_S  = SUM_W + $clog2(AVG_SAMPLES);
    localparam int REC_W  = SUM_W + 1;
    localparam int PROD_W = REC_S + SW;
    localparam logic [REC_W-1:0] REC_M = REC_W'(((64'd1 << REC_S) + 64'(AVG_SAMPLES) - 64'd1)
                                                / 64'(AVG_SAMPLES));
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 2);
    localparam logic [ntcl_pkg::TEMP_W-1:0] HOTTEST = ntcl_pkg::TEMP_W'(TABLE_ENTRIES - 1);

    ntcl_pkg::t_back_state r_state, n_state;

    logic [SUM_W-1:0]                r_sum;
    logic [SW-1:0]                   r_quot;
    logic [IDX_W-1:0]                r_idx;
    logic [ntcl_pkg::TEMP_W-1:0]     r_temp;
    logic [ntcl_pkg::STATUS_W-1:0]   r_status;
    logic                            r_out_valid;
    logic [SW-1:0]                   r_out_avg;
    logic [ntcl_pkg::TEMP_W-1:0]     r_out_temp;
    logic [ntcl_pkg::LIGHT_W-1:0]    r_out_light;
    logic [ntcl_pkg::STATUS_W-1:0]   r_out_status;

    logic [PROD_W-1:0] quot_prod;
    logic              below, above;
    logic              hit, walk_end;
    logic              slot_free;
    logic              pop, out_load;
    logic [SW:0]       light_inv;
    logic [SW+7:0]     light_prod;

    // Group average by multiplying with the reciprocal of the group size.
    assign quot_prod = PROD_W'(r_sum) * PROD_W'(REC_M);

    // Limit tests and one curve entry per walk step.
    assign below    = (r_quot < i_limits.low);
    assign above    = (r_quot > i_limits.high);
    assign hit      = (ntcl_pkg::curve_value(8'(r_idx)) < r_quot);
    assign walk_end = hit || (r_idx == LAST_IDX);

    // Light level from the finished average.
    assign light_inv  = ntcl_pkg::FULL_SCALE - {1'b0, r_quot};
    assign light_prod = light_inv * ntcl_pkg::PERCENT;

    assign slot_free = !r_out_valid || i_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ntcl_pkg::ST_IDLE: begin
                if (i_q_valid) n_state = ntcl_pkg::ST_DIVIDE;
            end
            ntcl_pkg::ST_DIVIDE: begin
                n_state = ntcl_pkg::ST_CHECK;
            end
            ntcl_pkg::ST_CHECK: begin
                n_state = (below || above) ? ntcl_pkg::ST_EMIT : ntcl_pkg::ST_WALK;
            end
            ntcl_pkg::ST_WALK: begin
                if (walk_end) n_state = ntcl_pkg::ST_EMIT;
            end
            ntcl_pkg::ST_EMIT: begin
                if (slot_free) n_state = ntcl_pkg::ST_IDLE;
            end
            default: n_state = ntcl_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ntcl_pkg::ST_IDLE: pop      = i_q_valid;
            ntcl_pkg::ST_EMIT: out_load = slot_free;
            default: begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntcl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath of the average, the limit check and the curve walk.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ntcl_pkg::ST_IDLE: begin
                if (pop) begin
                    r_sum <= i_q_sum;
                end
            end
            ntcl_pkg::ST_DIVIDE: begin
                r_quot <= quot_prod[REC_S +: SW];
            end
            ntcl_pkg::ST_CHECK: begin
                r_idx <= '0;
                if (below) begin
                    r_temp   <= HOTTEST;
                    r_status <= ntcl_pkg::STATUS_BELOW;
                end else if (above) begin
                    r_temp   <= '0;
                    r_status <= ntcl_pkg::STATUS_ABOVE;
                end else begin
                    r_status <= ntcl_pkg::STATUS_IN_TABLE;
                end
            end
            ntcl_pkg::ST_WALK: begin
                if (hit) begin
                    r_temp <= ntcl_pkg::TEMP_W'(r_idx);
                end else if (walk_end) begin
                    r_temp <= HOTTEST;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Output register; it frees the back end while a word waits downstream.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg    <= r_quot;
            r_out_temp   <= r_temp;
            r_out_light  <= light_prod[SW+6:SW];
            r_out_status <= r_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_average       = r_out_avg;
    assign o_temperature   = r_out_temp;
    assign o_light_percent = r_out_light;
    assign o_range_status  = r_out_status;

endmodule

[src/ntc_temperature_and_light_conditioner_unit.sv]
// Throughput: one sample word per cycle, except that the last word of a group waits while
// the queue is full. Per group the conditioner divides, checks the limits, walks up to
// TABLE_ENTRIES-1 curve entries when the average lies within the limits, and then emits;
// a two-entry queue of sums decouples the accumulator from the conditioner.
// Reset: synchronous, active low; clears the group sum, the queue, the conditioner and the
// output valid, and loads the limits with 267 and 3157. The curve is a constant table.
module ntc_temperature_and_light_conditioner_unit #(
    parameter int AVG_SAMPLES   = ntcl_pkg::AVG_SAMPLES_DEF,
    parameter int TABLE_ENTRIES = ntcl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ntcl_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ntcl_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ntcl_pkg::SAMPLE_W-1:0] o_average,
    output logic [ntcl_pkg::TEMP_W-1:0]   o_temperature,
    output logic [ntcl_pkg::LIGHT_W-1:0]  o_light_percent,
    output logic [ntcl_pkg::STATUS_W-1:0] o_range_status
);

    localparam int SUM_W = ntcl_pkg::SAMPLE_W + $clog2(AVG_SAMPLES);

    ntcl_pkg::t_limits r_limits;
    logic              push, full, q_valid, q_pop;
    logic [SUM_W-1:0]  push_sum, q_sum;

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.low  <= ntcl_pkg::LOW_LIMIT_RST;
            r_limits.high <= ntcl_pkg::HIGH_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ntcl_pkg::CFG_LOW_LIMIT:  r_limits.low  <= i_cfg_data;
                ntcl_pkg::CFG_HIGH_LIMIT: r_limits.high <= i_cfg_data;
                default:                  r_limits      <= r_limits;
            endcase
        end
    end

    // Group accumulator.
    ntcl_front #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_full     (full),
        .o_push     (push),
        .o_push_sum (push_sum)
    );

    // Queue of finished group sums.
    ntcl_queue #(
        .WIDTH (SUM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_sum),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_sum)
    );

    // Average, limits, curve walk and light level.
    ntcl_back #(
        .AVG_SAMPLES   (AVG_SAMPLES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SUM_W         (SUM_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_limits        (r_limits),
        .i_q_valid       (q_valid),
        .i_q_sum         (q_sum),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_average       (o_average),
        .o_temperature   (o_temperature),
        .o_light_percent (o_light_percent),
        .o_range_status  (o_range_status)
    );

endmodule
